// ===== rtl/bvie_pkg.sv =====
// Shared types and codes for the bounded vector insert/erase core.
package bvie_pkg;

	// Index width inside the core; it covers a count of up to 256 entries
	// and every value of the five-bit request fields.
	localparam int unsigned IDX_W = 9;

	// Request codes.
	typedef enum logic [2:0] {
		REQ_PUSH   = 3'd0,
		REQ_POP    = 3'd1,
		REQ_INSERT = 3'd2,
		REQ_ERASE  = 3'd3,
		REQ_READ   = 3'd4,
		REQ_RESIZE = 3'd5,
		REQ_CLEAR  = 3'd6
	} req_t;

	// Result error codes.
	typedef enum logic [2:0] {
		ERR_OK       = 3'd0,
		ERR_OVERFLOW = 3'd1,
		ERR_UNDERFLOW = 3'd2,
		ERR_BAD_POS  = 3'd3,
		ERR_BAD_SIZE = 3'd4
	} err_t;

	// Sequencer states: idle, or stepping through a multi-slot erase.
	typedef enum logic {
		ST_IDLE,
		ST_ERASE
	} seq_state_t;

	// Operation that every cell of the row applies at the same clock edge.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT_DN,
		CELL_TRIM
	} cell_cmd_t;

	// Control broadcast from the sequencer to the cell row.
	typedef struct packed {
		cell_cmd_t          cmd;
		logic [IDX_W-1:0]   idx;
	} cell_ctrl_t;

	// Request item.
	typedef struct packed {
		req_t        req_type;
		logic [4:0]  position;
		logic [31:0] elem_value;
		logic [4:0]  erase_count;
		logic [4:0]  new_size;
	} req_item_t;

	// Result item.
	typedef struct packed {
		logic [31:0] read_value;
		logic [4:0]  count_now;
		logic        is_full;
		logic        is_empty;
		err_t        error_code;
	} rsp_item_t;

endpackage

// ===== rtl/bvie_cell.sv =====
// One storage cell of the row: holds one entry and trades it with its neighbors.
module bvie_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned W   = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bvie_pkg::cell_ctrl_t ctrl,
	input  logic [W-1:0]        ins_val,
	input  logic [W-1:0]        left_d,
	input  logic [W-1:0]        right_d,
	output logic [W-1:0]        q
);
	import bvie_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [W-1:0] entry_q;
	logic [W-1:0] entry_d;

	// Each cell decides from its own index where its next value comes from.
	always_comb begin
		entry_d = entry_q;
		unique case (ctrl.cmd)
			CELL_HOLD: begin
				entry_d = entry_q;
			end
			CELL_INSERT: begin
				if (MY_IDX == ctrl.idx) begin
					entry_d = ins_val;
				end else if (MY_IDX > ctrl.idx) begin
					entry_d = left_d;
				end
			end
			CELL_SHIFT_DN: begin
				if (MY_IDX >= ctrl.idx) begin
					entry_d = right_d;
				end
			end
			CELL_TRIM: begin
				if (MY_IDX >= ctrl.idx) begin
					entry_d = '0;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	// Entry register; vacated slots always read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			entry_q <= entry_d;
		end
	end

	assign q = entry_q;

endmodule

// ===== rtl/bounded_vector_insert_erase_core.sv =====
// Top level of the bounded vector core: request sequencer, cell row and result register.
//
//  Channel | Direction | Handshake          | Payload
//  req     | in        | req_valid/req_stall | bvie_pkg::req_item_t
//  rsp     | out       | rsp_valid/rsp_stall | bvie_pkg::rsp_item_t
//
// Push, pop, insert, read, resize and clear complete on the request transfer; the result is valid
// in the cycle after the request transfer.
// Erase takes the request and then shifts the row down by one slot per cycle, the last
// shift waiting for a free result slot; it stalls the input until the last shift is done
// (not at all when erase_count is zero or the request is rejected).
// Reset clears every cell and the count at once; no request waits on it.
// A held result stalls new requests only until it is taken; one result is buffered.
module bounded_vector_insert_erase_core #(
	parameter int unsigned CAPACITY   = 16,
	parameter int unsigned ELEM_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  bvie_pkg::req_item_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output bvie_pkg::rsp_item_t  rsp
);
	import bvie_pkg::*;

	localparam int unsigned SW = (ELEM_WIDTH < 32) ? ELEM_WIDTH : 32;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam logic [IDX_W-1:0] CAP = IDX_W'(CAPACITY);

	seq_state_t        state_q, state_d;
	logic [CW-1:0]     count_q;
	logic [IDX_W-1:0]  cnt, cnt_nx;
	logic [IDX_W-1:0]  er_pos_q, er_pos_d;
	logic [4:0]        er_left_q, er_left_d;
	logic              out_valid_q;
	rsp_item_t         out_q, out_d;
	logic              load_out;
	logic              slot_free;
	logic              accept;
	cell_ctrl_t        ctrl;
	logic [SW-1:0]     ins_val;
	logic [SW-1:0]     cell_q [CAPACITY];
	logic [SW-1:0]     rd_val;
	logic [IDX_W-1:0]  pos_e, ecnt_e, nsz_e;

	assign cnt       = IDX_W'(count_q);
	assign pos_e     = IDX_W'(req.position);
	assign ecnt_e    = IDX_W'(req.erase_count);
	assign nsz_e     = IDX_W'(req.new_size);
	assign ins_val   = SW'(req.elem_value);
	assign slot_free = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || !slot_free;
	assign accept    = req_valid && !req_stall;

	// Cell row: each cell hands its entry to both neighbors.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [SW-1:0] left_d, right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_q[i+1];
		end
		bvie_cell #(
			.IDX (i),
			.W   (SW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.ins_val (ins_val),
			.left_d  (left_d),
			.right_d (right_d),
			.q       (cell_q[i])
		);
	end

	// Read port: select the cell at the requested position.
	always_comb begin
		rd_val = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (IDX_W'(i) == pos_e) begin
				rd_val = cell_q[i];
			end
		end
	end

	// Sequencer: checks each request, drives the cell row and builds the result.
	always_comb begin
		state_d   = state_q;
		cnt_nx    = cnt;
		er_pos_d  = er_pos_q;
		er_left_d = er_left_q;
		ctrl.cmd  = CELL_HOLD;
		ctrl.idx  = '0;
		load_out  = 1'b0;
		out_d.read_value = '0;
		out_d.error_code = ERR_OK;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					load_out = 1'b1;
					unique case (req.req_type)
						REQ_PUSH: begin
							if (cnt == CAP) begin
								out_d.error_code = ERR_OVERFLOW;
							end else begin
								ctrl.cmd = CELL_INSERT;
								ctrl.idx = cnt;
								cnt_nx   = cnt + IDX_W'(1);
							end
						end
						REQ_POP: begin
							if (cnt == '0) begin
								out_d.error_code = ERR_UNDERFLOW;
							end else begin
								ctrl.cmd = CELL_TRIM;
								ctrl.idx = cnt - IDX_W'(1);
								cnt_nx   = cnt - IDX_W'(1);
							end
						end
						REQ_INSERT: begin
							if (pos_e > cnt) begin
								out_d.error_code = ERR_BAD_POS;
							end else if (cnt == CAP) begin
								out_d.error_code = ERR_OVERFLOW;
							end else begin
								ctrl.cmd = CELL_INSERT;
								ctrl.idx = pos_e;
								cnt_nx   = cnt + IDX_W'(1);
							end
						end
						REQ_ERASE: begin
							if (pos_e > cnt) begin
								out_d.error_code = ERR_BAD_POS;
							end else if (pos_e + ecnt_e > cnt) begin
								out_d.error_code = ERR_BAD_SIZE;
							end else if (ecnt_e != '0) begin
								// The result goes out once the last shift is done.
								load_out  = 1'b0;
								er_pos_d  = pos_e;
								er_left_d = req.erase_count;
								state_d   = ST_ERASE;
							end
						end
						REQ_READ: begin
							if (pos_e >= cnt) begin
								out_d.error_code = ERR_BAD_POS;
							end else begin
								out_d.read_value = 32'(rd_val);
							end
						end
						REQ_RESIZE: begin
							if (nsz_e > CAP) begin
								out_d.error_code = ERR_BAD_SIZE;
							end else begin
								// Slots above the new size are zero either way.
								ctrl.cmd = CELL_TRIM;
								ctrl.idx = nsz_e;
								cnt_nx   = nsz_e;
							end
						end
						REQ_CLEAR: begin
							ctrl.cmd = CELL_TRIM;
							ctrl.idx = '0;
							cnt_nx   = '0;
						end
						default: begin
							out_d.error_code = ERR_OK;
						end
					endcase
				end
			end
			ST_ERASE: begin
				// One slot removed per cycle; the last step waits for a free result slot.
				if (er_left_q != 5'd1 || slot_free) begin
					ctrl.cmd  = CELL_SHIFT_DN;
					ctrl.idx  = er_pos_q;
					cnt_nx    = cnt - IDX_W'(1);
					er_left_d = er_left_q - 5'd1;
					if (er_left_q == 5'd1) begin
						load_out = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		out_d.count_now = cnt_nx[4:0];
		out_d.is_full   = (cnt_nx == CAP);
		out_d.is_empty  = (cnt_nx == '0);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			er_pos_q    <= '0;
			er_left_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= CW'(cnt_nx);
			er_pos_q  <= er_pos_d;
			er_left_q <= er_left_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= out_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the bounded vector insert/erase core.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bvie_pkg::*;

	localparam int unsigned CAPACITY     = 16;
	localparam int unsigned ELEM_WIDTH   = 32;
	localparam int unsigned IDLE_PERCENT = 22;
	localparam int unsigned HOLD_CYCLES  = 90;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT  = 300000;
	// Request code that the package leaves unassigned.
	localparam logic [2:0] REQ_UNUSED_CODE = 3'd7;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	// Shadow copy of the vector contents, updated on every accepted request.
	logic [ELEM_WIDTH-1:0] shadow_entries [CAPACITY];
	int unsigned           shadow_count;
	rsp_item_t             pending_results [$];

	int unsigned fail_count  = 0;
	int unsigned cycle_count = 0;
	bit          quiet       = 1'b0;
	bit          hold_req    = 1'b0;
	int unsigned hold_left   = 0;

	bounded_vector_insert_erase_core #(
		.CAPACITY   (CAPACITY),
		.ELEM_WIDTH (ELEM_WIDTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #6 clk = ~clk;

	// Zero every slot from lo upward.
	function automatic void shadow_zero_from(input int unsigned lo);
		for (int unsigned i = lo; i < CAPACITY; i++) begin
			shadow_entries[i] = '0;
		end
	endfunction

	// Apply one request to the shadow vector and return the result it should produce.
	function automatic rsp_item_t vector_apply(input req_item_t r);
		rsp_item_t             res;
		logic [ELEM_WIDTH-1:0] rd;
		err_t                  err;
		int unsigned           pos;
		int unsigned           ecnt;
		int unsigned           nsz;
		rd   = '0;
		err  = ERR_OK;
		pos  = r.position;
		ecnt = r.erase_count;
		nsz  = r.new_size;
		case (r.req_type)
			REQ_PUSH: begin
				if (shadow_count >= CAPACITY) begin
					err = ERR_OVERFLOW;
				end else begin
					shadow_entries[shadow_count] = r.elem_value;
					shadow_count++;
				end
			end
			REQ_POP: begin
				if (shadow_count == 0) begin
					err = ERR_UNDERFLOW;
				end else begin
					shadow_count--;
					shadow_entries[shadow_count] = '0;
				end
			end
			REQ_INSERT: begin
				// The position check takes priority over the full check.
				if (pos > shadow_count) begin
					err = ERR_BAD_POS;
				end else if (shadow_count >= CAPACITY) begin
					err = ERR_OVERFLOW;
				end else begin
					for (int unsigned i = shadow_count; i > pos; i--) begin
						shadow_entries[i] = shadow_entries[i-1];
					end
					shadow_entries[pos] = r.elem_value;
					shadow_count++;
				end
			end
			REQ_ERASE: begin
				if (pos > shadow_count) begin
					err = ERR_BAD_POS;
				end else if (pos + ecnt > shadow_count) begin
					err = ERR_BAD_SIZE;
				end else if (ecnt > 0) begin
					for (int unsigned i = pos; i + ecnt < shadow_count; i++) begin
						shadow_entries[i] = shadow_entries[i+ecnt];
					end
					shadow_count -= ecnt;
					shadow_zero_from(shadow_count);
				end
			end
			REQ_READ: begin
				if (pos >= shadow_count || pos >= CAPACITY) begin
					err = ERR_BAD_POS;
				end else begin
					rd = shadow_entries[pos];
				end
			end
			REQ_RESIZE: begin
				if (nsz > CAPACITY) begin
					err = ERR_BAD_SIZE;
				end else begin
					if (nsz < shadow_count) begin
						shadow_zero_from(nsz);
					end
					shadow_count = nsz;
				end
			end
			REQ_CLEAR: begin
				shadow_zero_from(0);
				shadow_count = 0;
			end
			default: begin
			end
		endcase
		res.read_value = rd;
		res.count_now  = 5'(shadow_count);
		res.is_full    = (shadow_count == CAPACITY);
		res.is_empty   = (shadow_count == 0);
		res.error_code = err;
		return res;
	endfunction

	function automatic req_item_t make_request(input req_t kind, input int unsigned pos,
			input logic [31:0] val, input int unsigned ecnt, input int unsigned nsz);
		req_item_t r;
		r.req_type    = kind;
		r.position    = 5'(pos);
		r.elem_value  = val;
		r.erase_count = 5'(ecnt);
		r.new_size    = 5'(nsz);
		return r;
	endfunction

	// Mostly legal requests sized to the current contents; the rest is raw noise.
	function automatic req_item_t random_request(input bit well_formed);
		req_item_t   r;
		int unsigned pick;
		int unsigned span;
		r.req_type    = req_t'($urandom_range(7));
		r.position    = 5'($urandom());
		r.elem_value  = $urandom();
		r.erase_count = 5'($urandom());
		r.new_size    = 5'($urandom());
		if (well_formed) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				r.req_type = REQ_PUSH;
			end else if (pick < 34) begin
				r.req_type = REQ_POP;
			end else if (pick < 54) begin
				r.req_type = REQ_INSERT;
				r.position = 5'($urandom_range(shadow_count));
			end else if (pick < 68) begin
				r.req_type = REQ_ERASE;
				r.position = 5'($urandom_range(shadow_count));
				span       = shadow_count - r.position;
				if (span > 3 && $urandom_range(3) != 0) begin
					r.erase_count = 5'($urandom_range(3));
				end else begin
					r.erase_count = 5'($urandom_range(span));
				end
			end else if (pick < 88) begin
				r.req_type = REQ_READ;
				r.position = (shadow_count == 0) ? 5'd0 : 5'($urandom_range(shadow_count - 1));
			end else if (pick < 96) begin
				r.req_type = REQ_RESIZE;
				r.new_size = 5'($urandom_range(CAPACITY));
			end else begin
				r.req_type = REQ_CLEAR;
			end
		end
		return r;
	endfunction

	// Offer one request and hold it until the transfer completes; called at a falling edge.
	task automatic send_request(input req_item_t item);
		while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Result side: random stalls, quiet stretches and one long hold-off.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left != 0) begin
			rsp_stall <= 1'b1;
			hold_left--;
		end else if (quiet) begin
			rsp_stall <= 1'b0;
		end else begin
			rsp_stall <= ($urandom_range(99) < IDLE_PERCENT);
		end
	end

	// Predict on each request transfer and check each result transfer in order.
	always @(posedge clk) begin
		rsp_item_t want;
		cycle_count++;
		if (arst_n && req_valid && !req_stall) begin
			pending_results.insert(pending_results.size(), vector_apply(req));
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result transfer, expected none, actual %p", $time, rsp);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp.read_value !== want.read_value) begin
					$display("%0t: read_value expected %0h actual %0h",
						$time, want.read_value, rsp.read_value);
					fail_count++;
				end
				if (rsp.count_now !== want.count_now) begin
					$display("%0t: count_now expected %0d actual %0d",
						$time, want.count_now, rsp.count_now);
					fail_count++;
				end
				if (rsp.is_full !== want.is_full) begin
					$display("%0t: is_full expected %0b actual %0b",
						$time, want.is_full, rsp.is_full);
					fail_count++;
				end
				if (rsp.is_empty !== want.is_empty) begin
					$display("%0t: is_empty expected %0b actual %0b",
						$time, want.is_empty, rsp.is_empty);
					fail_count++;
				end
				if (rsp.error_code !== want.error_code) begin
					$display("%0t: error_code expected %0d actual %0d",
						$time, want.error_code, rsp.error_code);
					fail_count++;
				end
			end
		end
	end

	// Requests against an empty vector.
	task automatic test_empty_edges();
		send_request(make_request(REQ_POP, 0, 32'h0, 0, 0));
		send_request(make_request(REQ_READ, 0, 32'h0, 0, 0));
		send_request(make_request(REQ_ERASE, 0, 32'h0, 0, 0));
	endtask

	// Insert and erase at the ends, in the middle and past the end.
	task automatic test_insert_erase();
		send_request(make_request(REQ_PUSH, 0, 32'hFFFF_FFFF, 0, 0));
		send_request(make_request(REQ_PUSH, 0, 32'h0000_0000, 0, 0));
		send_request(make_request(REQ_INSERT, 0, 32'hA5A5_A5A5, 0, 0));
		send_request(make_request(REQ_INSERT, 3, 32'h5A5A_5A5A, 0, 0));
		send_request(make_request(REQ_INSERT, 5, 32'h1234_5678, 0, 0));
		send_request(make_request(REQ_READ, 3, 32'h0, 0, 0));
		send_request(make_request(REQ_ERASE, 1, 32'h0, 2, 0));
		send_request(make_request(REQ_ERASE, 3, 32'h0, 1, 0));
		send_request(make_request(REQ_ERASE, 1, 32'h0, 2, 0));
		send_request(make_request(REQ_ERASE, 31, 32'h0, 31, 31));
	endtask

	// A full vector: overflow, ordering of the insert checks and size limits.
	task automatic test_full_edges();
		send_request(make_request(REQ_RESIZE, 0, 32'h0, 0, CAPACITY));
		send_request(make_request(REQ_READ, CAPACITY - 1, 32'h0, 0, 0));
		send_request(make_request(REQ_READ, CAPACITY, 32'h0, 0, 0));
		send_request(make_request(REQ_PUSH, 0, 32'hDEAD_BEEF, 0, 0));
		send_request(make_request(REQ_INSERT, CAPACITY + 1, 32'hDEAD_BEEF, 0, 0));
		send_request(make_request(REQ_INSERT, CAPACITY, 32'hDEAD_BEEF, 0, 0));
		send_request(make_request(REQ_RESIZE, 0, 32'h0, 0, CAPACITY + 1));
		send_request(make_request(REQ_RESIZE, 0, 32'h0, 0, 31));
	endtask

	// Unused code, a full erase, shrinking and regrowing, and clear.
	task automatic test_resize_clear();
		send_request(make_request(req_t'(REQ_UNUSED_CODE), 31, 32'hFFFF_FFFF, 31, 31));
		send_request(make_request(REQ_ERASE, 0, 32'h0, CAPACITY, 0));
		send_request(make_request(REQ_PUSH, 0, 32'h0000_0001, 0, 0));
		send_request(make_request(REQ_RESIZE, 0, 32'h0, 0, 0));
		send_request(make_request(REQ_RESIZE, 0, 32'h0, 0, 3));
		send_request(make_request(REQ_READ, 2, 32'h0, 0, 0));
		send_request(make_request(REQ_CLEAR, 0, 32'h0, 0, 0));
	endtask

	task automatic test_random_traffic(input int unsigned n);
		repeat (n) begin
			send_request(random_request($urandom_range(99) < 85));
		end
	endtask

	// The result side holds off while requests keep coming, so the core fills and stalls.
	task automatic test_result_backpressure();
		hold_req = 1'b1;
		test_random_traffic(40);
	endtask

	// Back-to-back transfers with no idling on either side.
	task automatic test_quiet_stretch();
		quiet = 1'b1;
		test_random_traffic(100);
		quiet = 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		shadow_zero_from(0);
		shadow_count = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_edges();
		test_insert_erase();
		test_full_edges();
		test_resize_clear();
		test_random_traffic(180);
		test_result_backpressure();
		test_quiet_stretch();
		test_random_traffic(180);
		req_valid <= 1'b0;

		// Drain outstanding results, then watch for stray transfers.
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog on the cycle counter.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
